>>> src/dur_pkg.sv
// ----------------------------------------------------------------------------
// dur_pkg
// Shared types and constants for the dual ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package dur_pkg;

    // Echo pulses at or above this width count as a timeout
    localparam logic [15:0] TIMEOUT_US = 16'd38000;

    // One second in microseconds, used by the speed check
    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_LEN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_LEN = 3'd7;

    typedef struct packed {
        logic [19:0]        scale_cm_per_us;
        logic signed [16:0] distance_offset;
        logic [22:0]        min_valid_range;
        logic [22:0]        max_valid_range;
        logic [15:0]        max_speed;
        logic               rail_origin;
        logic [22:0]        rail_length;
        logic [15:0]        sensor_length;
    } t_cfg;

    // Classified echo edge handed from the front to the back
    typedef struct packed {
        logic        side;
        logic        rising;
        logic [31:0] time_us;
        logic [15:0] width;
    } t_cmd;

endpackage

>>> src/dur_evt_if.sv
// ----------------------------------------------------------------------------
// dur_evt_if
// Echo edge channel: valid/ready handshake with channel, polarity and time.
// ----------------------------------------------------------------------------
interface dur_evt_if;
    logic        valid;
    logic        ready;
    logic        channel;
    logic        rising;
    logic [31:0] time_us;

    modport source (output valid, output channel, output rising, output time_us,
                    input ready);
    modport sink (input valid, input channel, input rising, input time_us,
                  output ready);
endinterface

>>> src/dur_res_if.sv
// ----------------------------------------------------------------------------
// dur_res_if
// Result channel: valid/ready handshake with fused position and side status.
// ----------------------------------------------------------------------------
interface dur_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] rail_position;
    logic               left_ok;
    logic               right_ok;
    logic signed [23:0] left_range;
    logic signed [23:0] right_range;

    modport source (output valid, output rail_position, output left_ok,
                    output right_ok, output left_range, output right_range,
                    input ready);
    modport sink (input valid, input rail_position, input left_ok,
                  input right_ok, input left_range, input right_range,
                  output ready);
endinterface

>>> src/dur_fifo.sv
// ----------------------------------------------------------------------------
// dur_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module dur_fifo #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

>>> src/dur_front.sv
// ----------------------------------------------------------------------------
// dur_front
// Accepts echo edges, keeps the echo start times and measures pulse width.
// ----------------------------------------------------------------------------
module dur_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dur_evt_if.sink       i_evt,
    input  logic          i_full,
    output logic          o_push,
    output dur_pkg::t_cmd o_cmd
);
    logic [31:0] r_start [2];
    logic [31:0] raw_width;

    assign i_evt.ready = !i_full;
    assign o_push      = i_evt.valid && !i_full;

    // Modulo-2^32 width, saturated to 16 bits
    assign raw_width      = i_evt.time_us - r_start[i_evt.channel];
    assign o_cmd.side     = i_evt.channel;
    assign o_cmd.rising   = i_evt.rising;
    assign o_cmd.time_us  = i_evt.time_us;
    assign o_cmd.width    = (raw_width[31:16] != '0) ? 16'hFFFF : raw_width[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start[0] <= '0;
            r_start[1] <= '0;
        end else if (o_push && i_evt.rising) begin
            r_start[i_evt.channel] <= i_evt.time_us;
        end
    end
endmodule

>>> src/dur_back.sv
// ----------------------------------------------------------------------------
// dur_back
// Sequencer with one shared multiplier: distance, range and speed checks,
// rail fusion and the output register.
// ----------------------------------------------------------------------------
module dur_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dur_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  dur_pkg::t_cmd i_cmd,
    output logic          o_pop,
    dur_res_if.source     o_res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_W = 3'd1;
    localparam logic [2:0] S_DIST  = 3'd2;
    localparam logic [2:0] S_MUL_D = 3'd3;
    localparam logic [2:0] S_MUL_S = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_FUSE  = 3'd6;

    logic [2:0]         r_state;
    logic               r_side;
    logic [31:0]        r_time;
    logic [15:0]        r_width;
    logic [31:0]        r_dt;
    logic [35:0]        r_prod;
    logic signed [23:0] r_dist;
    logic [44:0]        r_lhs;
    logic [47:0]        r_rhs;

    logic [31:0]        r_end [2];
    logic signed [23:0] r_side_dist [2];
    logic               r_side_ok [2];
    logic signed [23:0] r_held;

    logic               r_out_valid;
    logic signed [23:0] r_out_pos;
    logic               r_out_left_ok;
    logic               r_out_right_ok;
    logic signed [23:0] r_out_left;
    logic signed [23:0] r_out_right;

    logic [31:0]        mul_a;
    logic [19:0]        mul_b;
    logic [51:0]        mul_p;
    logic signed [24:0] diff;
    logic [24:0]        dd;
    logic               time_ok;
    logic               range_ok;
    logic               speed_ok;
    logic signed [23:0] rail_l;
    logic signed [23:0] rail_r;
    logic signed [24:0] rail_sum;
    logic signed [23:0] fused;
    logic               out_free;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[23:0];
        end
    endfunction

    function automatic logic signed [23:0] rail_frame(
        input logic               at_origin,
        input logic signed [23:0] d,
        input logic [22:0]        rail_len,
        input logic [15:0]        sensor_len
    );
        logic signed [25:0] half;
        logic signed [25:0] d_ext;
        half  = $signed({11'b0, sensor_len[15:1]});
        d_ext = {{2{d[23]}}, d};
        if (at_origin) begin
            return sat24(d_ext + half);
        end else begin
            return sat24($signed({3'b0, rail_len}) - d_ext - half);
        end
    endfunction

    // Shared multiplier operands per step
    always_comb begin
        unique case (r_state)
            S_MUL_W: begin
                mul_a = {16'b0, r_width};
                mul_b = i_cfg.scale_cm_per_us;
            end
            S_MUL_D: begin
                mul_a = {7'b0, dd};
                mul_b = dur_pkg::US_PER_S;
            end
            S_MUL_S: begin
                mul_a = r_dt;
                mul_b = {4'b0, i_cfg.max_speed};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 52'(mul_a) * 52'(mul_b);

    assign diff = {r_dist[23], r_dist} - {r_side_dist[r_side][23], r_side_dist[r_side]};
    assign dd   = diff[24] ? 25'(-diff) : 25'(diff);

    assign time_ok  = (r_width < dur_pkg::TIMEOUT_US);
    assign range_ok = (r_dist >= $signed({1'b0, i_cfg.min_valid_range}))
                   && (r_dist <= $signed({1'b0, i_cfg.max_valid_range}));
    // Speed scaled by 256 to match the q8 distance
    assign speed_ok = (r_dt != '0) && ({11'b0, r_lhs} < {r_rhs, 8'b0});

    assign rail_l   = rail_frame(i_cfg.rail_origin == 1'b0, r_side_dist[0],
                                 i_cfg.rail_length, i_cfg.sensor_length);
    assign rail_r   = rail_frame(i_cfg.rail_origin == 1'b1, r_side_dist[1],
                                 i_cfg.rail_length, i_cfg.sensor_length);
    assign rail_sum = {rail_l[23], rail_l} + {rail_r[23], rail_r};

    always_comb begin
        priority if (r_side_ok[0] && r_side_ok[1]) begin
            fused = rail_sum[24:1];
        end else if (r_side_ok[0]) begin
            fused = rail_l;
        end else if (r_side_ok[1]) begin
            fused = rail_r;
        end else begin
            fused = r_held;
        end
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_end[0]       <= '0;
            r_end[1]       <= '0;
            r_side_dist[0] <= '0;
            r_side_dist[1] <= '0;
            r_side_ok[0]   <= 1'b0;
            r_side_ok[1]   <= 1'b0;
            r_held         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= i_cmd.rising ? S_FUSE : S_MUL_W;
                    end
                end
                S_MUL_W: r_state <= S_DIST;
                S_DIST:  r_state <= S_MUL_D;
                S_MUL_D: r_state <= S_MUL_S;
                S_MUL_S: r_state <= S_UPD;
                S_UPD: begin
                    r_end[r_side]       <= r_time;
                    r_side_dist[r_side] <= r_dist;
                    r_side_ok[r_side]   <= time_ok && range_ok && speed_ok;
                    r_state             <= S_FUSE;
                end
                S_FUSE: begin
                    // Hold here until the output register frees up
                    if (out_free) begin
                        r_held  <= fused;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Load a new word, else drop the one just taken
            if (r_state == S_FUSE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_side  <= i_cmd.side;
            r_time  <= i_cmd.time_us;
            r_width <= i_cmd.width;
        end
        if (r_state == S_MUL_W) begin
            r_prod <= mul_p[35:0];
            r_dt   <= r_time - r_end[r_side];
        end
        if (r_state == S_DIST) begin
            r_dist <= $signed({4'b0, r_prod[35:16]})
                    + {{7{i_cfg.distance_offset[16]}}, i_cfg.distance_offset};
        end
        if (r_state == S_MUL_D) begin
            r_lhs <= mul_p[44:0];
        end
        if (r_state == S_MUL_S) begin
            r_rhs <= mul_p[47:0];
        end
        if (r_state == S_FUSE && out_free) begin
            r_out_pos      <= fused;
            r_out_left_ok  <= r_side_ok[0];
            r_out_right_ok <= r_side_ok[1];
            r_out_left     <= r_side_dist[0];
            r_out_right    <= r_side_dist[1];
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.rail_position = r_out_pos;
    assign o_res.left_ok       = r_out_left_ok;
    assign o_res.right_ok      = r_out_right_ok;
    assign o_res.left_range    = r_out_left;
    assign o_res.right_range   = r_out_right;
endmodule

>>> src/dual_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_echo_ranger
// Two-sensor echo ranging with validity checks and fused rail position.
// ----------------------------------------------------------------------------
// Latency: a falling edge steps the back through MUL_W, DIST, MUL_D, MUL_S,
//   UPD and FUSE into the output register; a rising edge only through FUSE.
// Throughput: a new edge is taken only in IDLE, and FUSE stalls while the
//   output is full; set by the back sequencer and its single shared multiplier.
// The queue takes up to QUEUE_DEPTH words while the back is busy.
// Reset (synchronous, active low) loads register defaults, clears the control state.
module dual_ultrasonic_echo_ranger #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dur_evt_if.sink                        i_evt,
    dur_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [dur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dur_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    dur_pkg::t_cfg r_cfg;
    dur_pkg::t_cmd push_cmd;
    dur_pkg::t_cmd pop_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_cm_per_us <= 20'd287777;
            r_cfg.distance_offset <= '0;
            r_cfg.min_valid_range <= 23'd512;
            r_cfg.max_valid_range <= 23'd102400;
            r_cfg.max_speed       <= 16'd500;
            r_cfg.rail_origin     <= 1'b0;
            r_cfg.rail_length     <= 23'd51200;
            r_cfg.sensor_length   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dur_pkg::CFG_SCALE:      r_cfg.scale_cm_per_us <= i_cfg_data[19:0];
                dur_pkg::CFG_OFFSET:     r_cfg.distance_offset <= $signed(i_cfg_data[16:0]);
                dur_pkg::CFG_MIN_RANGE:  r_cfg.min_valid_range <= i_cfg_data;
                dur_pkg::CFG_MAX_RANGE:  r_cfg.max_valid_range <= i_cfg_data;
                dur_pkg::CFG_MAX_SPEED:  r_cfg.max_speed       <= i_cfg_data[15:0];
                dur_pkg::CFG_ORIGIN:     r_cfg.rail_origin     <= i_cfg_data[0];
                dur_pkg::CFG_RAIL_LEN:   r_cfg.rail_length     <= i_cfg_data;
                dur_pkg::CFG_SENSOR_LEN: r_cfg.sensor_length   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dur_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    dur_fifo #(
        .WIDTH ($bits(dur_pkg::t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (pop_cmd)
    );

    dur_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_res       (o_res)
    );
endmodule

>>> tb/dur_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dur_result_checker
// Watches the echo edge, result and register ports of the ranger. Predicts
// each result word from its own copy of the per-side echo state and the
// registers, and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module dur_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dur_evt_if                             i_evt,
    dur_res_if                             i_res,
    input  logic                           i_cfg_we,
    input  logic [dur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dur_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_errors,
    output int                             o_readings,
    output int                             o_good_readings,
    output int                             o_fused_both
);

    typedef struct packed {
        logic signed [23:0] rail_position;
        logic               left_ok;
        logic               right_ok;
        logic signed [23:0] left_range;
        logic signed [23:0] right_range;
    } t_ranger_word;

    localparam longint POS_MAX = 64'sd8388607;
    localparam longint POS_MIN = -64'sd8388608;

    dur_pkg::t_cfg      ranger_cfg;
    logic [31:0]        echo_rise_us [2];
    logic [31:0]        echo_fall_us [2];
    logic signed [23:0] range_q8 [2];
    logic               range_ok [2];
    logic signed [23:0] held_pos;
    t_ranger_word       due_words [$];

    int err_n     = 0;
    int reading_n = 0;
    int good_n    = 0;
    int both_n    = 0;

    assign o_errors        = err_n;
    assign o_readings      = reading_n;
    assign o_good_readings = good_n;
    assign o_fused_both    = both_n;

    function automatic longint clamp24(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // Distance of one side converted into the rail frame
    function automatic longint rail_pos_of(input int side);
        longint half;
        longint d;
        half = longint'(ranger_cfg.sensor_length >> 1);
        d    = longint'(range_q8[side]);
        if (int'(ranger_cfg.rail_origin) == side) return clamp24(d + half);
        return clamp24(longint'(ranger_cfg.rail_length) - d - half);
    endfunction

    function automatic t_ranger_word step_ranger(input logic side, input logic rise,
                                                 input logic [31:0] t_us);
        logic [31:0]  width;
        logic [31:0]  dt;
        logic [15:0]  w16;
        longint       range_now;
        longint       prev;
        longint       dd;
        logic         ok_time;
        logic         ok_range;
        logic         ok_speed;
        longint       fused;
        t_ranger_word w;
        if (rise) begin
            echo_rise_us[side] = t_us;
        end else begin
            prev  = longint'(range_q8[side]);
            width = t_us - echo_rise_us[side];
            dt    = t_us - echo_fall_us[side];
            echo_fall_us[side] = t_us;
            w16  = (width > 32'd65535) ? 16'hFFFF : width[15:0];
            range_now = longint'((64'(w16) * 64'(ranger_cfg.scale_cm_per_us)) >> 16)
                        + longint'(ranger_cfg.distance_offset);
            range_now = clamp24(range_now);
            range_q8[side] = range_now[23:0];
            ok_time  = w16 < dur_pkg::TIMEOUT_US;
            ok_range = range_now >= longint'(ranger_cfg.min_valid_range) &&
                       range_now <= longint'(ranger_cfg.max_valid_range);
            dd       = (range_now >= prev) ? range_now - prev : prev - range_now;
            // cross-multiplied: distance step per second against the limit
            ok_speed = (dt != 32'd0) &&
                       (dd * 64'sd1000000 <
                        longint'(ranger_cfg.max_speed) * 64'sd256 * longint'(dt));
            range_ok[side] = ok_time && ok_range && ok_speed;
            reading_n++;
            if (range_ok[side]) good_n++;
        end
        if (range_ok[0] && range_ok[1]) begin
            fused    = (rail_pos_of(0) + rail_pos_of(1)) >>> 1;
            held_pos = fused[23:0];
            both_n++;
        end else if (range_ok[0]) begin
            fused    = rail_pos_of(0);
            held_pos = fused[23:0];
        end else if (range_ok[1]) begin
            fused    = rail_pos_of(1);
            held_pos = fused[23:0];
        end
        w = '{held_pos, range_ok[0], range_ok[1], range_q8[0], range_q8[1]};
        return w;
    endfunction

    function automatic void check_field(input string name, input logic signed [23:0] want_v,
                                        input logic signed [23:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_n++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_ranger_word want;
        if (!i_rst_n) begin
            ranger_cfg.scale_cm_per_us = 20'd287777;
            ranger_cfg.distance_offset = 17'sd0;
            ranger_cfg.min_valid_range = 23'd512;
            ranger_cfg.max_valid_range = 23'd102400;
            ranger_cfg.max_speed       = 16'd500;
            ranger_cfg.rail_origin     = 1'b0;
            ranger_cfg.rail_length     = 23'd51200;
            ranger_cfg.sensor_length   = 16'd0;
            for (int s = 0; s < 2; s++) begin
                echo_rise_us[s] = '0;
                echo_fall_us[s] = '0;
                range_q8[s]     = '0;
                range_ok[s]     = 1'b0;
            end
            held_pos = '0;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dur_pkg::CFG_SCALE:
                        ranger_cfg.scale_cm_per_us = i_cfg_data[19:0];
                    dur_pkg::CFG_OFFSET:
                        ranger_cfg.distance_offset = i_cfg_data[16:0];
                    dur_pkg::CFG_MIN_RANGE:
                        ranger_cfg.min_valid_range = i_cfg_data[22:0];
                    dur_pkg::CFG_MAX_RANGE:
                        ranger_cfg.max_valid_range = i_cfg_data[22:0];
                    dur_pkg::CFG_MAX_SPEED:
                        ranger_cfg.max_speed       = i_cfg_data[15:0];
                    dur_pkg::CFG_ORIGIN:
                        ranger_cfg.rail_origin     = i_cfg_data[0];
                    dur_pkg::CFG_RAIL_LEN:
                        ranger_cfg.rail_length     = i_cfg_data[22:0];
                    dur_pkg::CFG_SENSOR_LEN:
                        ranger_cfg.sensor_length   = i_cfg_data[15:0];
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with no expectation waiting");
                    err_n++;
                end else begin
                    want = due_words.pop_front();
                    check_field("rail_position", want.rail_position, i_res.rail_position);
                    check_field("left_ok", want.left_ok, i_res.left_ok);
                    check_field("right_ok", want.right_ok, i_res.right_ok);
                    check_field("left_range", want.left_range, i_res.left_range);
                    check_field("right_range", want.right_range, i_res.right_range);
                end
            end
            if (i_evt.valid && i_evt.ready)
                due_words.push_back(step_ranger(i_evt.channel, i_evt.rising, i_evt.time_us));
        end
        o_pending <= due_words.size();
    end

endmodule

>>> tb/tb_dual_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_ultrasonic_echo_ranger
// Drives echo edges into the ranger: a directed set of limit, wrap and fusion
// cases, then random ping sequences with noise over several register
// settings, with random idling on both sides and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb_dual_ultrasonic_echo_ranger;

    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   PHASES        = 6;
    localparam int   PHASE_WORDS   = 190;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   LONG_HOLD     = 300;
    localparam logic SIDE_LEFT     = 1'b0;
    localparam logic SIDE_RIGHT    = 1'b1;
    localparam logic ECHO_START    = 1'b1;
    localparam logic ECHO_END      = 1'b0;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [dur_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dur_pkg::CFG_DATA_W-1:0] cfg_data;

    dur_evt_if evt_ch ();
    dur_res_if res_ch ();

    int          edges_sent    = 0;
    int          settings_n    = 0;
    int          cycle_n       = 0;
    bit          gaps_on       = 1'b0;
    bit          long_hold_req = 1'b0;
    logic [31:0] now_us;
    logic [31:0] last_fall_us [2] = '{32'd0, 32'd0};
    int          pulse_us [2]     = '{2000, 2000};

    int chk_pending;
    int chk_errors;
    int chk_readings;
    int chk_good;
    int chk_both;

    always #10 i_clk = ~i_clk;

    dual_ultrasonic_echo_ranger u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dur_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_evt           (evt_ch),
        .i_res           (res_ch),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (chk_pending),
        .o_errors        (chk_errors),
        .o_readings      (chk_readings),
        .o_good_readings (chk_good),
        .o_fused_both    (chk_both)
    );

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side pacing: short random stalls, plus one long hold on request
    initial begin : sink_pacing
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic side, input logic rise, input logic [31:0] t_us);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.channel <= side;
        evt_ch.rising  <= rise;
        evt_ch.time_us <= t_us;
        do @(posedge i_clk); while (!evt_ch.ready);
        if (rise == ECHO_END) last_fall_us[side] = t_us;
        edges_sent++;
    endtask

    task automatic ping(input logic side, input logic [31:0] t_us, input int width_us);
        send_word(side, ECHO_START, t_us);
        send_word(side, ECHO_END, t_us + width_us);
    endtask

    task automatic put_reg(input logic [dur_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dur_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(input dur_pkg::t_cfg c);
        put_reg(dur_pkg::CFG_SCALE, 23'(c.scale_cm_per_us));
        put_reg(dur_pkg::CFG_OFFSET, 23'(c.distance_offset));
        put_reg(dur_pkg::CFG_MIN_RANGE, c.min_valid_range);
        put_reg(dur_pkg::CFG_MAX_RANGE, c.max_valid_range);
        put_reg(dur_pkg::CFG_MAX_SPEED, 23'(c.max_speed));
        put_reg(dur_pkg::CFG_ORIGIN, 23'(c.rail_origin));
        put_reg(dur_pkg::CFG_RAIL_LEN, c.rail_length);
        put_reg(dur_pkg::CFG_SENSOR_LEN, 23'(c.sensor_length));
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    // Drop valid, let every expected word come back, then let the block settle
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_words, input bit with_hold);
        int   stop_at;
        int   pick;
        logic side;
        stop_at = edges_sent + n_words;
        while (edges_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            side = 1'($urandom_range(0, 1));
            if (pick <= 6) begin
                // mostly slow drift so the speed check passes, now and then a jump
                if ($urandom_range(0, 7) == 0) begin
                    pulse_us[side] = $urandom_range(0, 70000);
                end else begin
                    pulse_us[side] += int'($urandom_range(0, 600)) - 300;
                    if (pulse_us[side] < 100) pulse_us[side] = 100;
                    if (pulse_us[side] > 30000) pulse_us[side] = 30000;
                end
                ping(side, now_us, pulse_us[side]);
                now_us += pulse_us[side] + $urandom_range(500, 70000);
            end else if (pick == 7) begin
                send_word(side, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? $urandom() : now_us + $urandom_range(0, 5000));
            end else if (pick == 8) begin
                // repeat the last echo end: zero interval
                send_word(side, ECHO_END, last_fall_us[side]);
            end else begin
                send_word(side, ECHO_START, now_us);
                now_us += $urandom();
            end
            if (with_hold && edges_sent >= stop_at - n_words / 2) begin
                long_hold_req = 1'b1;
                with_hold = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        dur_pkg::t_cfg setting;
        logic [31:0]   t0;
        i_rst_n        <= 1'b0;
        evt_ch.valid   <= 1'b0;
        evt_ch.channel <= SIDE_LEFT;
        evt_ch.rising  <= ECHO_END;
        evt_ch.time_us <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= dur_pkg::CFG_SCALE;
        cfg_data       <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        // Reset register values: fusion, speed, zero interval, wrap, saturation
        t0 = 32'd100_000_000;
        send_word(SIDE_RIGHT, ECHO_START, 32'd0);
        ping(SIDE_LEFT, t0, 2000);
        ping(SIDE_RIGHT, t0 + 1000, 3000);
        ping(SIDE_LEFT, t0 + 60000, 2000);
        send_word(SIDE_LEFT, ECHO_END, t0 + 62000);
        ping(SIDE_RIGHT, t0 + 120000, 4000);
        ping(SIDE_LEFT, t0 + 180000, 6000);
        ping(SIDE_LEFT, 32'hFFFF_F000, 6096);
        ping(SIDE_RIGHT, 32'hFFFF_FFFF, 3000);
        send_word(SIDE_RIGHT, ECHO_END, 32'h0010_0000);
        drain();

        // Unit scale so the range limits land on exact widths
        setting = '{scale_cm_per_us: 20'd65536, distance_offset: -17'sd1000,
                    min_valid_range: 23'd412, max_valid_range: 23'd36999,
                    max_speed: 16'd65535, rail_origin: 1'b1,
                    rail_length: 23'd40000, sensor_length: 16'd301};
        load_cfg(setting);
        t0 = 32'h2000_0000;
        ping(SIDE_LEFT, t0, 1411);
        ping(SIDE_LEFT, t0 + 100000, 1412);
        ping(SIDE_RIGHT, t0 + 200000, 37999);
        ping(SIDE_RIGHT, t0 + 300000, 38000);
        drain();

        now_us = 32'h3000_0000;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: setting = '{20'd287777, 17'sd0, 23'd512, 23'd102400, 16'd500, 1'b0,
                               23'd51200, 16'd0};
                1: setting = '{20'hFFFFF, 17'sd65535, 23'd0, 23'h7FFFFF, 16'hFFFF, 1'b1,
                               23'h7FFFFF, 16'hFFFF};
                2: setting = '{20'd0, -17'sd65536, 23'd0, 23'd0, 16'd0, 1'b0, 23'd0, 16'd0};
                default: begin
                    setting.scale_cm_per_us = 20'($urandom_range(200000, 400000));
                    setting.distance_offset = 17'(int'($urandom_range(0, 4000)) - 2000);
                    setting.min_valid_range = 23'($urandom_range(0, 2000));
                    setting.max_valid_range = 23'($urandom_range(60000, 300000));
                    setting.max_speed       = 16'($urandom_range(200, 5000));
                    setting.rail_origin     = 1'($urandom_range(0, 1));
                    setting.rail_length     = 23'($urandom_range(0, 23'h7FFFFF));
                    setting.sensor_length   = 16'($urandom_range(0, 16'hFFFF));
                end
            endcase
            load_cfg(setting);
            // one phase without idling mid-run, and none in the last phase
            gaps_on = (p != 3) && (p != PHASES - 1);
            run_random(PHASE_WORDS, p == 1 || p == 4);
            drain();
        end

        $display("Sent %0d echo edge words under %0d loaded register settings.",
                 edges_sent, settings_n);
        $display("%0d echo readings, %0d passed every check, %0d words fused from both sides.",
                 chk_readings, chk_good, chk_both);
        if (chk_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
src/dur_pkg.sv
src/dur_evt_if.sv
src/dur_res_if.sv
src/dur_fifo.sv
src/dur_front.sv
src/dur_back.sv
src/dual_ultrasonic_echo_ranger.sv
tb/dur_result_checker.sv
tb/tb_dual_ultrasonic_echo_ranger.sv
